### hw/rtl/lcf_pkg.sv
package lcf_pkg;

  localparam int unsigned CodeW    = 32;
  localparam int unsigned CsW      = 4;
  localparam int unsigned ReqW     = 4;
  localparam int unsigned NumRows  = 10;
  localparam int unsigned RowW     = 4;

  localparam logic [CsW-1:0] CS_UTF8   = 4'd0;
  localparam logic [CsW-1:0] CS_LATIN3 = 4'd3;
  localparam logic [CsW-1:0] CS_MAX    = 4'd10;

  // Configuration register indexes
  localparam logic CFG_CHARSET     = 1'b0;
  localparam logic CFG_IGNORE_CASE = 1'b1;

  typedef enum logic [ReqW-1:0] {
    REQ_SPACE   = 4'd0,
    REQ_HEX     = 4'd1,
    REQ_DIGIT   = 4'd2,
    REQ_ALPHA   = 4'd3,
    REQ_LOWER   = 4'd4,
    REQ_UPPER   = 4'd5,
    REQ_BLANK   = 4'd6,
    REQ_PERCENT = 4'd7,
    REQ_NOTEOL  = 4'd8,
    REQ_CTRL    = 4'd9,
    REQ_ANY     = 4'd10,
    REQ_EQUAL   = 4'd11
  } req_e;

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [CodeW-1:0] char_code;
    logic [CodeW-1:0] pattern_code;
    logic             invert;
  } in_item_t;

  // Per-charset bitmaps over 0xA0..0xBF, bit 0 doubles as the "0xD7/0xF7 are letters" flag
  localparam logic [31:0] LOW_BITS [NumRows] = '{
    32'h00002000, 32'hDE6A0000, 32'h9E420000, 32'hDE6A0004, 32'h00002000,
    32'hDF7E2001, 32'h85000000, 32'hD7AA2823, 32'h21002100, 32'hA7086003
  };

  localparam logic [31:0] UP_BITS [NumRows] = '{
    32'h00000000, 32'h0000DE6A, 32'h00008C42, 32'h20005E6A, 32'h00000000,
    32'h0000DF7E, 32'h00008500, 32'h38159552, 32'h50100040, 32'h5014944A
  };

  localparam logic [7:0] HI_FOLD [NumRows][32] = '{
    '{8'hA0,8'hA1,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'hAA,8'hAB,8'hAC,8'hAD,8'hAE,8'hAF,
      8'hB0,8'hB1,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBB,8'hBB,8'hBC,8'hBD,8'hBE,8'hBF},
    '{8'hA0,8'hB1,8'hA2,8'hB3,8'hA4,8'hB5,8'hB6,8'hA7,8'hA8,8'hB9,8'hBA,8'hBB,8'hBC,8'hAD,8'hBE,8'hBF,
      8'hB0,8'hB1,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBB,8'hBB,8'hBC,8'hBD,8'hBE,8'hBF},
    '{8'hA0,8'hB1,8'hA2,8'hA3,8'hA4,8'hA5,8'hB6,8'hA7,8'hA8,8'hB9,8'hBA,8'hBB,8'hBC,8'hAD,8'hAE,8'hAF,
      8'hB0,8'hB1,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBB,8'hBB,8'hBC,8'hBD,8'hBE,8'hBF},
    '{8'hA0,8'hB1,8'hA2,8'hB3,8'hA4,8'hB5,8'hB6,8'hA7,8'hA8,8'hB9,8'hBA,8'hBB,8'hBC,8'hAD,8'hBE,8'hAF,
      8'hB0,8'hB1,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBB,8'hBB,8'hBC,8'hBF,8'hBE,8'hBF},
    '{8'hA0,8'hA1,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hA8,8'hA9,8'hAA,8'hAB,8'hAC,8'hAD,8'hAE,8'hAF,
      8'hB0,8'hB1,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBB,8'hBB,8'hBC,8'hBD,8'hBE,8'hBF},
    '{8'hA0,8'hB1,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hA7,8'hB8,8'hB9,8'hBA,8'hBB,8'hBC,8'hAD,8'hBE,8'hBF,
      8'hB0,8'hB1,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBB,8'hBB,8'hBC,8'hBD,8'hBE,8'hBF},
    '{8'hA0,8'hA1,8'hA2,8'hA3,8'hA4,8'hA5,8'hA6,8'hA7,8'hB8,8'hA9,8'hBA,8'hAB,8'hAC,8'hAD,8'hAE,8'hBF,
      8'hB0,8'hB1,8'hB2,8'hB3,8'hB4,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBB,8'hBB,8'hBC,8'hBD,8'hBE,8'hBF},
    '{8'hA0,8'hA2,8'hA2,8'hA3,8'hA5,8'hA5,8'hAB,8'hA7,8'hB8,8'hA9,8'hBA,8'hAB,8'hBC,8'hAD,8'hAE,8'hFF,
      8'hB1,8'hB1,8'hB3,8'hB3,8'hB5,8'hB5,8'hB6,8'hB9,8'hB8,8'hB9,8'hBF,8'hBB,8'hBC,8'hBE,8'hBE,8'hBF},
    '{8'hA0,8'hA1,8'hA2,8'hA3,8'hA4,8'hA5,8'hA8,8'hA7,8'hA8,8'hA9,8'hAA,8'hAB,8'hAC,8'hAD,8'hAE,8'hAF,
      8'hB0,8'hB1,8'hB2,8'hB3,8'hB8,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBB,8'hBB,8'hBD,8'hBD,8'hFF,8'hBF},
    '{8'hA0,8'hA2,8'hA2,8'hB3,8'hA4,8'hA5,8'hA8,8'hA7,8'hA8,8'hA9,8'hBA,8'hAB,8'hAE,8'hAD,8'hAE,8'hBF,
      8'hB0,8'hB1,8'hB9,8'hB3,8'hB8,8'hB5,8'hB6,8'hB7,8'hB8,8'hB9,8'hBB,8'hBB,8'hBD,8'hBD,8'hFF,8'hBF}
  };

  // cs is already saturated to 0..10; UTF-8 maps to row 0, which it never reads
  function automatic logic [RowW-1:0] row_of(input logic [CsW-1:0] cs);
    logic [RowW-1:0] r;
    r = (cs == CS_UTF8) ? '0 : (cs - 4'd1);
    return r;
  endfunction

  function automatic logic in_rng(input logic [CodeW-1:0] c, input logic [CodeW-1:0] lo,
                                  input logic [CodeW-1:0] hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic logic is_ascii_letter(input logic [CodeW-1:0] c);
    return in_rng(c, 32'h41, 32'h5A) || in_rng(c, 32'h61, 32'h7A);
  endfunction

  function automatic logic is_low(input logic [CodeW-1:0] c, input logic [CsW-1:0] cs);
    logic [31:0] m;
    logic        res;
    m   = LOW_BITS[row_of(cs)];
    res = 1'b0;
    if (in_rng(c, 32'h61, 32'h7A)) begin
      res = 1'b1;
    end else if (cs == CS_UTF8) begin
      if (in_rng(c, 32'hC39F, 32'hC3BF))      res = (c != 32'hC3B7);
      else if (in_rng(c, 32'hC480, 32'hC4B7)) res = c[0];
      else if (in_rng(c, 32'hC4B8, 32'hC588)) res = !c[0];
      else if (in_rng(c, 32'hC589, 32'hC5B7)) res = c[0];
      else if (in_rng(c, 32'hC5B9, 32'hC5BE)) res = !c[0];
    end else begin
      if (c == 32'hAD)                        res = 1'b0;
      else if (c == 32'hFF)                   res = m[13];
      else if (in_rng(c, 32'hDF, 32'hFE)) begin
        if (cs == CS_LATIN3 && (c == 32'hF0 || c == 32'hE3)) res = 1'b0;
        else if (c == 32'hF7)                                res = m[0];
        else                                                 res = 1'b1;
      end else if (in_rng(c, 32'hA1, 32'hBF)) res = m[c[4:0]];
    end
    return res;
  endfunction

  function automatic logic is_up(input logic [CodeW-1:0] c, input logic [CsW-1:0] cs);
    logic [RowW-1:0] r;
    logic            res;
    r   = row_of(cs);
    res = 1'b0;
    if (in_rng(c, 32'h41, 32'h5A)) begin
      res = 1'b1;
    end else if (cs == CS_UTF8) begin
      if (in_rng(c, 32'hC380, 32'hC39E))      res = (c != 32'hC397);
      else if (in_rng(c, 32'hC480, 32'hC4B7)) res = !c[0];
      else if (in_rng(c, 32'hC4B8, 32'hC588)) res = c[0];
      else if (in_rng(c, 32'hC58A, 32'hC5B8)) res = !c[0];
      else if (in_rng(c, 32'hC5B9, 32'hC5BE)) res = c[0];
    end else begin
      if (in_rng(c, 32'hC0, 32'hDE)) begin
        if (cs == CS_LATIN3 && (c == 32'hD0 || c == 32'hC3)) res = 1'b0;
        else if (c == 32'hD7)                                res = LOW_BITS[r][0];
        else                                                 res = 1'b1;
      end else if (in_rng(c, 32'hA1, 32'hBF)) res = UP_BITS[r][c[4:0]];
    end
    return res;
  endfunction

  function automatic logic is_alpha(input logic [CodeW-1:0] c, input logic [CsW-1:0] cs);
    logic [RowW-1:0] r;
    logic            sym;
    logic            res;
    r   = row_of(cs);
    sym = LOW_BITS[r][0];
    res = 1'b0;
    if (is_ascii_letter(c)) begin
      res = 1'b1;
    end else if (cs == CS_UTF8) begin
      if (in_rng(c, 32'hC380, 32'hC3BF))      res = (c != 32'hC397) && (c != 32'hC3B7);
      else if (in_rng(c, 32'hC480, 32'hC5BE)) res = 1'b1;
    end else begin
      if (cs == CS_LATIN3 &&
          (c == 32'hF0 || c == 32'hE3 || c == 32'hD0 || c == 32'hC3)) res = 1'b0;
      else if (in_rng(c, 32'hC0, 32'hFF))
        res = (c != 32'hD7 || sym) && (c != 32'hF7 || sym);
      else if (in_rng(c, 32'hA1, 32'hBF))
        res = UP_BITS[r][c[4:0]] | LOW_BITS[r][c[4:0]];
    end
    return res;
  endfunction

  function automatic logic [CodeW-1:0] fold(input logic [CodeW-1:0] c,
                                            input logic [CsW-1:0] cs);
    logic [CodeW-1:0] res;
    res = c;
    if (is_up(c, cs)) begin
      if (cs == CS_UTF8) begin
        if (c == 32'hC5B8)      res = 32'hC3BF;
        else if (c == 32'hC4BF) res = 32'hC580;
        else if (c <= 32'hC39E) res = c + 32'd32;
        else                    res = c + 32'd1;
      end else if (in_rng(c, 32'hA1, 32'hBF)) begin
        res = {24'd0, HI_FOLD[row_of(cs)][c[4:0]]};
      end else begin
        res = c + 32'd32;
      end
    end
    return res;
  endfunction

endpackage

### hw/rtl/lcf_in_if.sv
interface lcf_in_if;
  logic                         valid;
  logic                         ready;
  logic [lcf_pkg::ReqW-1:0]     req_type;
  logic [lcf_pkg::CodeW-1:0]    char_code;
  logic [lcf_pkg::CodeW-1:0]    pattern_code;
  logic                         invert;

  modport source (output valid, output req_type, output char_code, output pattern_code,
                  output invert, input ready);
  modport sink   (input valid, input req_type, input char_code, input pattern_code,
                  input invert, output ready);
endinterface

### hw/rtl/lcf_out_if.sv
interface lcf_out_if;
  logic                         valid;
  logic                         ready;
  logic                         matched;
  logic [lcf_pkg::CodeW-1:0]    folded_code;

  modport source (output valid, output matched, output folded_code, input ready);
  modport sink   (input valid, input matched, input folded_code, output ready);
endinterface

### hw/rtl/latin_char_class_and_fold.sv
// Character classifier and case folder. Each transaction on in_i carries a class
// request, a character code (packed UTF-8 or one ISO-8859 byte, per the charset
// register), a pattern code and an invert flag; out_o returns the match flag and the
// lower-case fold of the character. One transaction is taken every cycle while the
// output does not stall; its result is computed between the input register and the
// result register and is valid once registered. An output stall holds the result
// register and a full input register, so the input stops once two transactions
// are waiting. Write charset and ignore_case only while no transaction is in flight.
module latin_char_class_and_fold (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [lcf_pkg::CsW-1:0]       cfg_wdata_i,
  lcf_in_if.sink                        in_i,
  lcf_out_if.source                     out_o
);

  logic [lcf_pkg::CsW-1:0]      charset_q;
  logic                         ignore_case_q;
  logic [lcf_pkg::CsW-1:0]      cs;

  logic                         s1_valid_q;
  lcf_pkg::in_item_t            s1_q;
  logic                         s1_adv;
  logic                         in_ready;

  logic                         out_valid_q;
  logic                         matched_q;
  logic [lcf_pkg::CodeW-1:0]    folded_q;
  logic                         matched_d;
  logic [lcf_pkg::CodeW-1:0]    folded_d;

  logic [lcf_pkg::CodeW-1:0]    c;
  logic                         class_t;
  logic                         blank;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      charset_q     <= lcf_pkg::CS_UTF8;
      ignore_case_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == lcf_pkg::CFG_CHARSET) begin
        charset_q <= cfg_wdata_i;
      end else begin
        ignore_case_q <= cfg_wdata_i[0];
      end
    end
  end

  // charsets above Latin-10 behave as Latin-10
  assign cs = (charset_q > lcf_pkg::CS_MAX) ? lcf_pkg::CS_MAX : charset_q;

  // handshake
  assign s1_adv      = !out_valid_q || out_o.ready;
  assign in_ready    = !s1_valid_q || s1_adv;
  assign in_i.ready  = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      s1_q.req_type     <= in_i.req_type;
      s1_q.char_code    <= in_i.char_code;
      s1_q.pattern_code <= in_i.pattern_code;
      s1_q.invert       <= in_i.invert;
    end
    if (s1_valid_q && s1_adv) begin
      matched_q <= matched_d;
      folded_q  <= folded_d;
    end
  end

  // classification
  assign c        = s1_q.char_code;
  assign folded_d = lcf_pkg::fold(c, cs);
  assign blank    = (c == 32'h20) || (c == 32'h09) || (c == 32'hA0) || (c == 32'hC2A0);

  always_comb begin
    class_t = 1'b0;
    case (s1_q.req_type)
      lcf_pkg::REQ_SPACE:   class_t = blank || (c == 32'h0B) || (c == 32'h0C) ||
                                      (c == 32'h0D) || (c == 32'h0A);
      lcf_pkg::REQ_HEX:     class_t = lcf_pkg::in_rng(c, 32'h30, 32'h39) ||
                                      lcf_pkg::in_rng(c, 32'h61, 32'h66) ||
                                      lcf_pkg::in_rng(c, 32'h41, 32'h46);
      lcf_pkg::REQ_DIGIT:   class_t = lcf_pkg::in_rng(c, 32'h30, 32'h39);
      lcf_pkg::REQ_ALPHA:   class_t = lcf_pkg::is_alpha(c, cs);
      lcf_pkg::REQ_LOWER:   class_t = lcf_pkg::is_low(c, cs);
      lcf_pkg::REQ_UPPER:   class_t = lcf_pkg::is_up(c, cs);
      lcf_pkg::REQ_BLANK:   class_t = blank;
      lcf_pkg::REQ_PERCENT: class_t = (c == 32'h25);
      lcf_pkg::REQ_NOTEOL:  class_t = (c != 32'h0D) && (c != 32'h0A);
      lcf_pkg::REQ_CTRL:    class_t = lcf_pkg::in_rng(c, 32'h01, 32'h1F) ||
                                      lcf_pkg::in_rng(c, 32'h80, 32'h9F) ||
                                      lcf_pkg::in_rng(c, 32'hC280, 32'hC29F);
      lcf_pkg::REQ_ANY:     class_t = 1'b1;
      lcf_pkg::REQ_EQUAL:   class_t = (c == s1_q.pattern_code) ||
                                      (ignore_case_q &&
                                       (lcf_pkg::fold(s1_q.pattern_code, cs) == folded_d));
      default:              class_t = 1'b0;
    endcase
  end

  always_comb begin
    if (s1_q.req_type == lcf_pkg::REQ_EQUAL) begin
      matched_d = class_t ^ s1_q.invert;
    end else if (s1_q.req_type < lcf_pkg::REQ_EQUAL) begin
      // a zero code never belongs to a class, inverted or not
      matched_d = (c != '0) && (class_t ^ s1_q.invert);
    end else begin
      matched_d = 1'b0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.matched     = matched_q;
  assign out_o.folded_code = folded_q;

  // assertions
  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_ready |=> s1_valid_q)
    else $error("accepted transaction did not reach the input register");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_o.ready |-> !in_ready)
    else $error("input taken while both stages are held");

  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_adv |=> out_valid_q)
    else $error("input register advanced without a result");

  a_zero_code_nomatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_adv && (s1_q.char_code == '0) &&
    (s1_q.req_type != lcf_pkg::REQ_EQUAL) |=> !out_o.matched)
    else $error("zero code matched a class");

endmodule
